// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- sv/ides_pkg.sv -----
// Types, constants and codes for the image directory entry scanner.
package ides_pkg;

    localparam int HEADER_GAP   = 16;
    localparam int NAME_LEN     = 8;
    localparam int HEADER_BYTES = 16;
    localparam int SKIP_LEN     = (HEADER_GAP > NAME_LEN) ? (HEADER_GAP - NAME_LEN) : 0;

    localparam logic [63:0] NAME_PATTERN = 64'h6663_7274_2E62_696E;

    typedef logic [5:0] count_t;
    typedef logic [3:0] fill_t;
    typedef logic [63:0] window_t;

    localparam count_t SKIP_COUNT   = count_t'(SKIP_LEN);
    localparam count_t HEADER_COUNT = count_t'(HEADER_BYTES);
    localparam fill_t  FILL_FULL    = fill_t'(NAME_LEN);

    localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_CUT_SHORT = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } ides_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] start_block;
        logic [31:0] data_length;
        logic [31:0] meta_word;
    } ides_out_t;

endpackage

// ----- sv/ides_window_match.sv -----
// Eight-byte sliding window with fill count and name pattern compare.
module ides_window_match (
    input  ides_pkg::window_t window_reg,
    input  ides_pkg::fill_t   fill_reg,
    input  logic [7:0]        data_byte,
    output ides_pkg::window_t window_next,
    output ides_pkg::fill_t   fill_next,
    output logic              hit
);
    import ides_pkg::*;

    always_comb
    begin
        window_next = {window_reg[55:0], data_byte};
        fill_next   = (fill_reg < FILL_FULL) ? (fill_reg + fill_t'(1)) : fill_reg;
        hit         = (fill_next >= FILL_FULL) && (window_next == NAME_PATTERN);
    end

endmodule

// ----- sv/image_directory_entry_scanner.sv -----
// Top level of the image directory entry scanner.
// A result is loaded into the output register when the beat that causes it is accepted.
// Throughput: one byte beat per cycle; byte_ready drops only while a result waits.
// The window compare and header accumulate sit between the state and result registers.
// Reset (rst_n low, asynchronous) returns the scanner to searching with empty state.
// The final byte of an image also returns all scan state to its reset value.
module image_directory_entry_scanner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  ides_pkg::ides_in_t  byte_beat,
    output logic                result_valid,
    input  logic                result_ready,
    output ides_pkg::ides_out_t result_beat
);
    import ides_pkg::*;

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_HEADER = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    window_t     window_reg, window_next, window_shift;
    fill_t       fill_reg, fill_next, fill_inc;
    logic [1:0]  phase_reg, phase_next;
    count_t      count_reg, count_next, count_inc;
    logic [31:0] block_reg, block_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] meta_reg, meta_next;
    logic        zero_seen_reg, zero_seen_next;
    logic        hit;
    logic        emit;
    logic [7:0]  meta_byte;
    ides_out_t   beat_next;
    logic        result_valid_reg;
    ides_out_t   result_beat_reg;
    logic        accept;

    ides_window_match u_window (
        .window_reg  (window_reg),
        .fill_reg    (fill_reg),
        .data_byte   (byte_beat.data_byte),
        .window_next (window_shift),
        .fill_next   (fill_inc),
        .hit         (hit)
    );

    assign byte_ready   = !result_valid_reg || result_ready;
    assign accept       = byte_valid && byte_ready;
    assign count_inc    = count_reg + count_t'(1);
    assign result_valid = result_valid_reg;
    assign result_beat  = result_beat_reg;

    always_comb
    begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        block_next     = block_reg;
        length_next    = length_reg;
        meta_next      = meta_reg;
        zero_seen_next = zero_seen_reg;
        emit           = 1'b0;
        meta_byte      = zero_seen_reg ? 8'd0 : byte_beat.data_byte;
        beat_next      = '{status: STATUS_NOT_FOUND, start_block: 32'd0,
                           data_length: 32'd0, meta_word: 32'd0};

        unique case (phase_reg)
            PH_SEARCH:
            begin
                window_next = window_shift;
                fill_next   = fill_inc;
                if (hit && !byte_beat.last_byte)
                begin
                    count_next = '0;
                    phase_next = (SKIP_COUNT == '0) ? PH_HEADER : PH_SKIP;
                end
                emit = byte_beat.last_byte;
            end
            PH_SKIP:
            begin
                count_next = count_inc;
                if (count_inc >= SKIP_COUNT)
                begin
                    count_next = '0;
                    phase_next = PH_HEADER;
                end
                emit             = byte_beat.last_byte;
                beat_next.status = STATUS_CUT_SHORT;
            end
            PH_HEADER:
            begin
                priority if (count_reg < count_t'(8))
                begin
                    block_next = {block_reg[23:0], byte_beat.data_byte};
                end
                else if (count_reg < count_t'(12))
                begin
                    length_next = {length_reg[23:0], byte_beat.data_byte};
                end
                else
                begin
                    // Zero out every meta byte after the first zero one.
                    if (meta_byte == 8'd0)
                    begin
                        zero_seen_next = 1'b1;
                    end
                    meta_next = {meta_reg[23:0], meta_byte};
                end
                count_next = count_inc;
                if (count_inc >= HEADER_COUNT)
                begin
                    emit       = 1'b1;
                    beat_next  = '{status: STATUS_FOUND, start_block: block_next,
                                   data_length: length_next, meta_word: meta_next};
                    phase_next = PH_DONE;
                    count_next = '0;
                end
                else if (byte_beat.last_byte)
                begin
                    emit             = 1'b1;
                    beat_next.status = STATUS_CUT_SHORT;
                end
            end
            PH_DONE:
            begin
                // Ignore bytes until the final one.
            end
            default:
            begin
            end
        endcase

        if (byte_beat.last_byte)
        begin
            window_next    = '0;
            fill_next      = '0;
            phase_next     = PH_SEARCH;
            count_next     = '0;
            block_next     = '0;
            length_next    = '0;
            meta_next      = '0;
            zero_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= '0;
            fill_reg         <= '0;
            phase_reg        <= PH_SEARCH;
            count_reg        <= '0;
            block_reg        <= '0;
            length_reg       <= '0;
            meta_reg         <= '0;
            zero_seen_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                window_reg       <= window_next;
                fill_reg         <= fill_next;
                phase_reg        <= phase_next;
                count_reg        <= count_next;
                block_reg        <= block_next;
                length_reg       <= length_next;
                meta_reg         <= meta_next;
                zero_seen_reg    <= zero_seen_next;
                result_valid_reg <= emit;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat only when this byte produces one.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            result_beat_reg <= beat_next;
        end
    end

endmodule

// ----- sv/ides_checker.sv -----
// Port-level assertion checker for the scanner, bound to the top level.
`include "assert_macros.svh"

module ides_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                byte_ready,
    input logic                result_valid,
    input logic                result_ready,
    input ides_pkg::ides_out_t result_beat
);
    import ides_pkg::*;

    logic result_stall;
    logic other_status;
    logic carries_data;

    assign result_stall = result_valid && !result_ready;
    assign other_status = result_valid && (result_beat.status != STATUS_FOUND);
    assign carries_data = (result_beat.start_block != 32'd0)
                       || (result_beat.data_length != 32'd0)
                       || (result_beat.meta_word != 32'd0);

    // A stalled result beat holds.
    `ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result_beat))

    // Take no byte while a result beat is stalled, and always be ready for one when the output is empty.
    `ASSERT_SAME(a_stall_blocks, result_stall, !byte_ready)
    `ASSERT_SAME(a_empty_ready, !result_valid, byte_ready)

    // Status stays in range; only a found header carries data.
    `ASSERT_SAME(a_status_range, result_valid, result_beat.status <= STATUS_CUT_SHORT)
    `ASSERT_SAME(a_no_data_unless_found, other_status, !carries_data)

endmodule

bind image_directory_entry_scanner ides_checker u_ides_checker (.*);

// ----- dv/tb_top.sv -----
// Testbench for the image directory entry scanner: random images, stalls, result checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ides_pkg::*;

    localparam int GAP_SKIP       = (HEADER_GAP > 8) ? (HEADER_GAP - 8) : 0;
    localparam int RANDOM_BYTES   = 1300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {PH_SEARCHING, PH_SKIPPING, PH_READING, PH_DONE} scan_phase_e;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    ides_in_t  byte_beat = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    ides_out_t result_beat;

    ides_in_t   pending_bytes[$];
    ides_out_t  expected_entries[$];
    logic [7:0] image_bytes[$];

    int total_bytes = 0;
    int accepted_bytes = 0;
    int send_idle;
    int recv_idle;
    int mismatches = 0;
    int stall_cycles = 0;

    // scanner state as predicted
    logic [63:0] window_q = '0;
    int          fill_q = 0;
    scan_phase_e phase_q = PH_SEARCHING;
    int          count_q = 0;
    logic [31:0] block_q = '0;
    logic [31:0] length_q = '0;
    logic [31:0] meta_q = '0;
    bit          zero_seen_q = 1'b0;

    image_directory_entry_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_beat    (byte_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

    always #5 clk = ~clk;

    function automatic void clear_scan();
        window_q    = '0;
        fill_q      = 0;
        phase_q     = PH_SEARCHING;
        count_q     = 0;
        block_q     = '0;
        length_q    = '0;
        meta_q      = '0;
        zero_seen_q = 1'b0;
    endfunction

    function automatic void scan_byte(input ides_in_t beat);
        ides_out_t  entry;
        logic [7:0] meta_byte;
        bit         give;
        entry = '0;
        give  = 1'b0;
        case (phase_q)
            PH_SEARCHING:
            begin
                window_q = {window_q[55:0], beat.data_byte};
                if (fill_q < 8)
                    fill_q++;
                // a match on the final byte does not count
                if (fill_q >= 8 && window_q == NAME_PATTERN && !beat.last_byte)
                begin
                    count_q = 0;
                    phase_q = (GAP_SKIP == 0) ? PH_READING : PH_SKIPPING;
                end
                if (beat.last_byte)
                begin
                    entry.status = STATUS_NOT_FOUND;
                    give = 1'b1;
                end
            end
            PH_SKIPPING:
            begin
                count_q++;
                if (count_q >= GAP_SKIP)
                begin
                    count_q = 0;
                    phase_q = PH_READING;
                end
                if (beat.last_byte)
                begin
                    entry.status = STATUS_CUT_SHORT;
                    give = 1'b1;
                end
            end
            PH_READING:
            begin
                if (count_q < 8)
                    block_q = {block_q[23:0], beat.data_byte};
                else if (count_q < 12)
                    length_q = {length_q[23:0], beat.data_byte};
                else
                begin
                    // zero every meta byte after the first zero
                    meta_byte = zero_seen_q ? 8'h00 : beat.data_byte;
                    if (meta_byte == 8'h00)
                        zero_seen_q = 1'b1;
                    meta_q = {meta_q[23:0], meta_byte};
                end
                count_q++;
                if (count_q >= HEADER_BYTES)
                begin
                    entry.status      = STATUS_FOUND;
                    entry.start_block = block_q;
                    entry.data_length = length_q;
                    entry.meta_word   = meta_q;
                    give    = 1'b1;
                    phase_q = PH_DONE;
                    count_q = 0;
                end
                else if (beat.last_byte)
                begin
                    entry.status = STATUS_CUT_SHORT;
                    give = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (give)
            expected_entries.push_back(entry);
        if (beat.last_byte)
            clear_scan();
    endfunction

    function automatic logic [7:0] any_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] any_word();
        return {any_byte(), any_byte(), any_byte(), any_byte()};
    endfunction

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++)
            image_bytes.push_back(any_byte());
    endtask

    // push the first n bytes of the entry name
    task automatic add_name(input int n);
        for (int i = 0; i < n; i++)
            image_bytes.push_back(NAME_PATTERN[63 - 8 * i -: 8]);
    endtask

    task automatic add_header(input logic [63:0] blk, input logic [31:0] len,
                              input logic [31:0] meta);
        for (int i = 0; i < 8; i++)
            image_bytes.push_back(blk[63 - 8 * i -: 8]);
        for (int i = 0; i < 4; i++)
            image_bytes.push_back(len[31 - 8 * i -: 8]);
        for (int i = 0; i < 4; i++)
            image_bytes.push_back(meta[31 - 8 * i -: 8]);
    endtask

    // mark the final byte and hand the image to the driver
    task automatic close_image();
        ides_in_t beat;
        if (image_bytes.size() == 0)
            image_bytes.push_back(any_byte());
        foreach (image_bytes[i])
        begin
            beat.data_byte = image_bytes[i];
            beat.last_byte = (i == image_bytes.size() - 1);
            pending_bytes.push_back(beat);
        end
        image_bytes.delete();
    endtask

    always_comb
    begin
        if (total_bytes == 0 || accepted_bytes * 3 < total_bytes)
        begin
            send_idle = 33;
            recv_idle = 56;
        end
        else if (accepted_bytes * 3 < total_bytes * 2)
        begin
            send_idle = 56;
            recv_idle = 33;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                scan_byte(byte_beat);
                accepted_bytes <= accepted_bytes + 1;
            end
            // hold the beat until it is taken
            if (!byte_valid || byte_ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    byte_valid <= 1'b1;
                    byte_beat  <= pending_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        ides_out_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_entries.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected none, actual status %0d start %h length %h meta %h",
                             $time, result_beat.status, result_beat.start_block,
                             result_beat.data_length, result_beat.meta_word);
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (result_beat.status !== want.status
                        || result_beat.start_block !== want.start_block
                        || result_beat.data_length !== want.data_length
                        || result_beat.meta_word !== want.meta_word)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected status %0d start %h length %h meta %h",
                                 $time, want.status, want.start_block, want.data_length,
                                 want.meta_word);
                        $display("%0t:           actual   status %0d start %h length %h meta %h",
                                 $time, result_beat.status, result_beat.start_block,
                                 result_beat.data_length, result_beat.meta_word);
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        clear_scan();

        // lone final bytes
        image_bytes.push_back(8'hFF);
        close_image();
        image_bytes.push_back(8'h00);
        close_image();
        // name completed by the final byte
        add_name(8);
        close_image();
        // end arrives during the skip
        add_name(8);
        add_noise(1);
        close_image();
        // broken prefix, then a header that completes on the final byte
        add_noise(2);
        add_name(3);
        add_name(8);
        add_noise(GAP_SKIP);
        add_header(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 32'h4100_7FFF);
        close_image();
        // later bytes after a found header, a second name among them
        add_name(8);
        add_noise(GAP_SKIP);
        add_header(64'h0123_4567_89AB_CDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_name(8);
        close_image();
        // end arrives inside the header
        add_name(8);
        add_noise(GAP_SKIP);
        add_header(64'h0, 32'h8000_0001, 32'h0000_0000);
        repeat (11) void'(image_bytes.pop_back());
        close_image();

        while (pending_bytes.size() < RANDOM_BYTES)
        begin
            kind = $urandom_range(9);
            add_noise($urandom_range(0, 6));
            if (kind == 0)
                add_noise($urandom_range(1, 30));
            else if (kind == 1)
            begin
                add_name($urandom_range(1, 7));
                add_noise($urandom_range(0, 8));
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    add_name($urandom_range(1, 7));
                add_name(8);
                add_noise(GAP_SKIP);
                add_header({any_word(), any_word()}, any_word(), any_word());
                if ($urandom_range(2) == 0)
                    add_noise($urandom_range(1, 10));
                // drop a tail so the end may land on the name, skip or header, or in the trailing noise
                if (kind <= 3)
                    repeat ($urandom_range(1, GAP_SKIP + HEADER_BYTES + 1))
                        void'(image_bytes.pop_back());
            end
            close_image();
        end
        total_bytes = pending_bytes.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || byte_valid || expected_entries.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_entries.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
